// File: rtl/vsaq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vsaq_pkg;

	// Field widths
	localparam int HR_W    = 9;
	localparam int OX_W    = 8;
	localparam int TEMP_W  = 11;
	localparam int RUN_W   = 8;
	localparam int MS_W    = 16;
	localparam int IDX_W   = 3;
	localparam int CDATA_W = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	// Plausibility windows
	localparam logic [HR_W-1:0]          HR_PLAUS_MIN   = 9'd25;
	localparam logic [HR_W-1:0]          HR_PLAUS_MAX   = 9'd240;
	localparam logic [OX_W-1:0]          OX_PLAUS_MIN   = 8'd50;
	localparam logic [OX_W-1:0]          OX_PLAUS_MAX   = 8'd100;
	localparam logic signed [TEMP_W-1:0] TEMP_PLAUS_MIN = 11'sd100;
	localparam logic signed [TEMP_W-1:0] TEMP_PLAUS_MAX = 11'sd450;

	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
	localparam logic [MS_W-1:0]  MS_MAX  = 16'd65535;

	// Command codes on the input tuser
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_READING = 1'b1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_HR_LOW    = 3'd0,
		CFG_HR_HIGH   = 3'd1,
		CFG_OX_LOW    = 3'd2,
		CFG_TEMP_LOW  = 3'd3,
		CFG_TEMP_HIGH = 3'd4,
		CFG_CONFIRM   = 3'd5,
		CFG_BEEP      = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [HR_W-1:0]          hr_low;
		logic [HR_W-1:0]          hr_high;
		logic [6:0]               ox_low;
		logic signed [TEMP_W-1:0] temp_low;
		logic signed [TEMP_W-1:0] temp_high;
		logic [RUN_W-1:0]         confirm;
		logic [MS_W-1:0]          beep;
	} cfg_t;

	// Result of the per-reading check
	typedef struct packed {
		logic            report;
		logic [HR_W-1:0] hr_clean;
		logic [OX_W-1:0] ox_clean;
		logic            contact;
		logic            out_now;
	} chk_t;

endpackage

`default_nettype wire

// File: rtl/vsaq_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module vsaq_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [vsaq_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [vsaq_pkg::CDATA_W-1:0]  wr_data,
	output vsaq_pkg::cfg_t                     cfg
);

	vsaq_pkg::cfg_t cfg_q;

	// Register file, reset to the default limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hr_low    <= 9'd50;
			cfg_q.hr_high   <= 9'd120;
			cfg_q.ox_low    <= 7'd90;
			cfg_q.temp_low  <= 11'sd350;
			cfg_q.temp_high <= 11'sd380;
			cfg_q.confirm   <= 8'd3;
			cfg_q.beep      <= 16'd400;
		end else if (wr_en) begin
			unique case (vsaq_pkg::cfg_idx_t'(wr_index))
				vsaq_pkg::CFG_HR_LOW:    cfg_q.hr_low    <= wr_data[vsaq_pkg::HR_W-1:0];
				vsaq_pkg::CFG_HR_HIGH:   cfg_q.hr_high   <= wr_data[vsaq_pkg::HR_W-1:0];
				vsaq_pkg::CFG_OX_LOW:    cfg_q.ox_low    <= wr_data[6:0];
				vsaq_pkg::CFG_TEMP_LOW:  cfg_q.temp_low  <= wr_data[vsaq_pkg::TEMP_W-1:0];
				vsaq_pkg::CFG_TEMP_HIGH: cfg_q.temp_high <= wr_data[vsaq_pkg::TEMP_W-1:0];
				vsaq_pkg::CFG_CONFIRM:   cfg_q.confirm   <= wr_data[vsaq_pkg::RUN_W-1:0];
				vsaq_pkg::CFG_BEEP:      cfg_q.beep      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/vsaq_check.sv
`timescale 1ns / 1ps
`default_nettype none

module vsaq_check (
	input  wire logic                               command,
	input  wire logic [vsaq_pkg::HR_W-1:0]          heart_rate_raw,
	input  wire logic [vsaq_pkg::OX_W-1:0]          oxygen_raw,
	input  wire logic signed [vsaq_pkg::TEMP_W-1:0] temp_tenths,
	input  wire logic                               temp_fault,
	input  wire vsaq_pkg::cfg_t                     cfg,
	output vsaq_pkg::chk_t                          chk
);

	logic                        report;
	logic                        hr_ok, ox_ok, temp_ok;
	logic [vsaq_pkg::HR_W-1:0]   hr_c;
	logic [vsaq_pkg::OX_W-1:0]   ox_c;
	logic                        contact;
	logic                        hr_out, ox_out, temp_out;

	assign report = (command == vsaq_pkg::CMD_READING);

	// Plausibility windows; ticks report zeros
	assign hr_ok = (heart_rate_raw >= vsaq_pkg::HR_PLAUS_MIN) &&
		(heart_rate_raw <= vsaq_pkg::HR_PLAUS_MAX);
	assign ox_ok = (oxygen_raw >= vsaq_pkg::OX_PLAUS_MIN) &&
		(oxygen_raw <= vsaq_pkg::OX_PLAUS_MAX);
	assign hr_c = (report && hr_ok) ? heart_rate_raw : '0;
	assign ox_c = (report && ox_ok) ? oxygen_raw : '0;
	assign contact = (hr_c != '0) && (ox_c != '0);

	// Limit checks
	assign hr_out = (hr_c < cfg.hr_low) || (hr_c > cfg.hr_high);
	assign ox_out = ox_c < {1'b0, cfg.ox_low};
	assign temp_ok = !temp_fault && (temp_tenths >= vsaq_pkg::TEMP_PLAUS_MIN) &&
		(temp_tenths <= vsaq_pkg::TEMP_PLAUS_MAX);
	assign temp_out = temp_ok &&
		((temp_tenths < cfg.temp_low) || (temp_tenths > cfg.temp_high));

	assign chk.report   = report;
	assign chk.hr_clean = hr_c;
	assign chk.ox_clean = ox_c;
	assign chk.contact  = contact;
	assign chk.out_now  = contact && (hr_out || ox_out || temp_out);

endmodule

`default_nettype wire

// File: rtl/vsaq_alarm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vsaq_alarm_ctrl (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 step,
	input  wire vsaq_pkg::chk_t                       chk,
	input  wire vsaq_pkg::cfg_t                       cfg,
	output logic                                      res_report,
	output logic [vsaq_pkg::OUT_TDATA_W-1:0]          res_data
);

	logic [vsaq_pkg::RUN_W-1:0] run_q, run_d;
	logic                       alarm_q, alarm_d;
	logic                       buzz_q, buzz_d;
	logic [vsaq_pkg::MS_W-1:0]  ms_q, ms_d;
	logic                       red_q, red_d;
	logic                       green_q, green_d;
	logic                       report_s2;
	logic [vsaq_pkg::HR_W-1:0]  hr_s2;
	logic [vsaq_pkg::OX_W-1:0]  ox_s2;
	logic                       contact_s2;

	// Next state for one tick or reading
	always_comb begin
		run_d   = run_q;
		alarm_d = alarm_q;
		buzz_d  = buzz_q;
		ms_d    = ms_q;
		red_d   = red_q;
		green_d = green_q;
		if (!chk.report) begin
			if (ms_q != vsaq_pkg::MS_MAX) begin
				ms_d = ms_q + 1'b1;
			end
		end else begin
			if (chk.out_now) begin
				if (run_q != vsaq_pkg::RUN_MAX) begin
					run_d = run_q + 1'b1;
				end
			end else begin
				run_d = '0;
			end
			alarm_d = run_d >= cfg.confirm;
			red_d   = alarm_d;
			green_d = !alarm_d;
			if (!alarm_d) begin
				buzz_d = 1'b0;
			end else if (ms_q > cfg.beep) begin
				buzz_d = !buzz_q;
				ms_d   = '0;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			alarm_q <= 1'b0;
			buzz_q  <= 1'b0;
			ms_q    <= '0;
			red_q   <= 1'b0;
			green_q <= 1'b0;
		end else if (step) begin
			run_q   <= run_d;
			alarm_q <= alarm_d;
			buzz_q  <= buzz_d;
			ms_q    <= ms_d;
			red_q   <= red_d;
			green_q <= green_d;
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (step) begin
			report_s2  <= chk.report;
			hr_s2      <= chk.hr_clean;
			ox_s2      <= chk.ox_clean;
			contact_s2 <= chk.contact;
		end
	end

	assign res_report = report_s2;
	assign res_data = {2'b00, contact_s2, ox_s2, hr_s2, buzz_q, green_q, red_q, alarm_q};

endmodule

`default_nettype wire

// File: rtl/vital_sign_alarm_qualifier_unit.sv
// Vital-sign alarm qualifier. Each input beat is either a millisecond
// tick or a sensor reading (selected by s_axis_tuser) and produces exactly
// one output beat. A beat is registered on entry. While it waits in the
// input register it is checked, and once the output register is free it
// is folded into the alarm state and written to the output register. One
// beat can be taken every clock while the output side keeps up. While an
// output beat waits, the input register takes one more beat, and then the
// input stalls until the output is taken. Heart rate and SpO2 outside
// their plausible windows read as zero, and the alarm is raised after a
// configurable run of out-of-range readings. Limits must be written
// through the cfg port only while no beat is in flight; the block does not
// enforce this, and cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module vital_sign_alarm_qualifier_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// [8:0] heart_rate_raw, [16:9] oxygen_raw, [27:17] temp_tenths,
	// [28] temp_fault, [31:29] zero
	input  wire logic [vsaq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// [0] command
	input  wire logic                                  s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [0] alarm, [1] led_red, [2] led_green, [3] buzzer,
	// [12:4] heart_rate_clean, [20:13] oxygen_clean, [21] has_contact, [23:22] zero
	output logic [vsaq_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
	// [0] is_report
	output logic                                       m_axis_tuser,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [vsaq_pkg::IDX_W-1:0]            cfg_index,
	input  wire logic [vsaq_pkg::CDATA_W-1:0]          cfg_data
);

	vsaq_pkg::cfg_t cfg;
	vsaq_pkg::chk_t chk;

	logic                                valid_s1;
	logic [vsaq_pkg::IN_TDATA_W-1:0]     data_s1;
	logic                                cmd_s1;
	logic                                out_valid_q;
	logic                                out_free;
	logic                                step;
	logic                                in_take;

	// Handshake control
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= s_axis_tdata;
			cmd_s1  <= s_axis_tuser;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	vsaq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	vsaq_check u_check (
		.command        (cmd_s1),
		.heart_rate_raw (data_s1[8:0]),
		.oxygen_raw     (data_s1[16:9]),
		.temp_tenths    (data_s1[27:17]),
		.temp_fault     (data_s1[28]),
		.cfg            (cfg),
		.chk            (chk)
	);

	vsaq_alarm_ctrl u_alarm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.chk        (chk),
		.cfg        (cfg),
		.res_report (m_axis_tuser),
		.res_data   (m_axis_tdata)
	);

endmodule

`default_nettype wire
